>>> hw/rtl/htlp_pkg.sv
// shared types, codes and constants of the linear probing hash table
package htlp_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int KEY_BYTES_DEF = 8;
  localparam int MIN_SLOTS     = 8;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  // prime 2^40 + 0x1b3: the multiply splits into a shift and a small product
  localparam int          FNV_SHIFT = 40;
  localparam logic [8:0]  FNV_LOW   = 9'h1B3;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [63:0] TAG_EMPTY = 64'd0;
  localparam logic [63:0] TAG_TOMB  = 64'd1;
  localparam logic [63:0] TAG_MIN   = 64'd2;

  typedef struct packed {
    logic [63:0] tag;
    logic [63:0] key;
    logic [3:0]  len;
    logic [63:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // largest power of two not above the slot limit
  function automatic int top_slots(input int max_slots);
    int p;
    p = MIN_SLOTS;
    while (p * 2 <= max_slots) p = p * 2;
    return p;
  endfunction

endpackage

>>> hw/rtl/htlp_ram.sv
// generic single write port ram with registered read
module htlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/hash_table_linear_probe_core.sv
// An item is hashed one key byte per round, then each probe step is a read state and a check
// state, and a done state hands over the result. One item at a time: a new item is taken
// only in idle, after the last result is handed over. A set that grows the table first
// clears the other bank over the doubled size, then reads every old slot and moves each live
// entry by probing into the new bank. Reset and every cfg write clear the first table_size
// slots of the active bank, with in_stall high; reset gives table_size 8 and an empty table.
module hash_table_linear_probe_core #(
  parameter int MAX_SLOTS = htlp_pkg::MAX_SLOTS_DEF,
  parameter int KEY_BYTES = htlp_pkg::KEY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_key_bytes,
  input  logic [3:0]  in_key_length,
  input  logic [63:0] in_value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_value_out,
  output logic [9:0]  out_entry_count,
  output logic [10:0] out_table_size
);

  import htlp_pkg::*;

  localparam int TOP_SLOTS = top_slots(MAX_SLOTS);
  localparam int AW        = $clog2(MAX_SLOTS);
  localparam int SW        = AW + 1;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_HASH  = 11'b00000000100,
    S_GCLR  = 11'b00000001000,
    S_GRD   = 11'b00000010000,
    S_GCHK  = 11'b00000100000,
    S_GPRD  = 11'b00001000000,
    S_GPCHK = 11'b00010000000,
    S_PRD   = 11'b00100000000,
    S_PCHK  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  // size after rounding up, minimum eight, capped at the top size
  function automatic logic [SW-1:0] round_size(input logic [10:0] n);
    logic [31:0] p;
    p = 32'(MIN_SLOTS);
    for (int k = 0; k < SW; k++) begin
      if (p < 32'(n) && p < 32'(TOP_SLOTS)) p = p << 1;
    end
    return p[SW-1:0];
  endfunction

  state_t         state_r, state_nxt;
  logic [SW-1:0]  size_r, size_nxt;
  logic [SW-1:0]  count_r, count_nxt;
  logic           bank_r, bank_nxt;
  logic [SW-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]  pidx_r, pidx_nxt;
  logic [SW-1:0]  nstep_r, nstep_nxt;
  logic           tomb_v_r, tomb_v_nxt;
  logic [AW-1:0]  tomb_r, tomb_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [63:0]    key_r, key_nxt;
  logic [3:0]     len_r, len_nxt;
  logic [63:0]    val_r, val_nxt;
  logic [63:0]    hash_r, hash_nxt;
  logic [3:0]     hcnt_r, hcnt_nxt;
  entry_t         gent_r, gent_nxt;
  logic [1:0]     res_status_r, res_status_nxt;
  logic [63:0]    res_value_r, res_value_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [63:0]    out_value_r, out_value_nxt;
  logic [9:0]     out_count_r, out_count_nxt;
  logic [10:0]    out_size_r, out_size_nxt;

  logic           ram_we;
  logic           ram_wbank;
  logic [AW-1:0]  ram_waddr;
  entry_t         ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] rd0, rd1;
  entry_t         rd_act, rd_new;

  // two banks: the active table and the target of a grow
  htlp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SLOTS)) u_bank0 (
    .clk     (clk),
    .wr_en   (ram_we && !ram_wbank),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (rd0)
  );

  htlp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SLOTS)) u_bank1 (
    .clk     (clk),
    .wr_en   (ram_we && ram_wbank),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (rd1)
  );

  assign rd_act = bank_r ? entry_t'(rd1) : entry_t'(rd0);
  assign rd_new = bank_r ? entry_t'(rd0) : entry_t'(rd1);

  // main control
  always_comb begin
    logic [SW-1:0]  mask, nsize, nmask;
    logic [SW+1:0]  need_v;
    logic           need_grow, can_grow;
    logic [63:0]    hx, hfin;
    logic [3:0]     len_c;
    logic [63:0]    kmask;
    logic           last_i, last_p;
    logic           resolve, found, free;
    logic [AW-1:0]  where;
    logic           out_free;

    state_nxt      = state_r;
    size_nxt       = size_r;
    count_nxt      = count_r;
    bank_nxt       = bank_r;
    idx_nxt        = idx_r;
    pidx_nxt       = pidx_r;
    nstep_nxt      = nstep_r;
    tomb_v_nxt     = tomb_v_r;
    tomb_nxt       = tomb_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    val_nxt        = val_r;
    hash_nxt       = hash_r;
    hcnt_nxt       = hcnt_r;
    gent_nxt       = gent_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_size_nxt   = out_size_r;
    ram_we         = 1'b0;
    ram_wbank      = bank_r;
    ram_waddr      = pidx_r;
    ram_wdata      = '0;
    ram_raddr      = pidx_r;

    mask      = size_r - 1'b1;
    nsize     = size_r << 1;
    nmask     = nsize - 1'b1;
    need_v    = ({2'b00, count_r} + 1'b1) << 1;
    need_grow = need_v > {2'b00, size_r};
    can_grow  = {size_r, 1'b0} <= (SW+1)'(TOP_SLOTS);
    last_i    = idx_r == mask;
    last_p    = nstep_r == mask;
    out_free  = !out_valid_r || !out_stall;

    // one fnv-1a round on the next key byte
    hx   = hash_r ^ {56'd0, key_r[hcnt_r[2:0]*8 +: 8]};
    hfin = (hash_r < TAG_MIN) ? TAG_MIN : hash_r;

    // input key trimmed to its length
    len_c = (in_key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_key_length;
    for (int b = 0; b < 8; b++) begin
      kmask[b*8 +: 8] = (4'(b) < len_c) ? 8'hFF : 8'h00;
    end

    // probe step outcome
    resolve = 1'b0;
    found   = 1'b0;
    free    = 1'b0;
    where   = pidx_r;
    if (rd_act.tag == TAG_EMPTY) begin
      resolve = 1'b1;
      free    = 1'b1;
      where   = tomb_v_r ? tomb_r : pidx_r;
    end else if (rd_act.tag == TAG_TOMB) begin
      if (last_p) begin
        resolve = 1'b1;
        free    = 1'b1;
        where   = tomb_v_r ? tomb_r : pidx_r;
      end
    end else if (rd_act.tag == hash_r && rd_act.len == len_r && rd_act.key == key_r) begin
      resolve = 1'b1;
      found   = 1'b1;
    end else if (last_p) begin
      resolve = 1'b1;
      free    = tomb_v_r;
      where   = tomb_r;
    end

    // result register drains on transfer
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        idx_nxt   = idx_r + 1'b1;
        if (last_i) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          len_nxt   = len_c;
          key_nxt   = in_key_bytes & kmask;
          val_nxt   = in_value_in;
          hash_nxt  = FNV_BASIS;
          hcnt_nxt  = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hcnt_r != len_r) begin
          hash_nxt = (hx << FNV_SHIFT) + hx * 64'(FNV_LOW);
          hcnt_nxt = hcnt_r + 1'b1;
        end else begin
          hash_nxt      = hfin;
          res_value_nxt = '0;
          pidx_nxt      = hfin[AW-1:0] & mask[AW-1:0];
          nstep_nxt     = '0;
          tomb_v_nxt    = 1'b0;
          case (op_r)
            OP_SET: begin
              if (!need_grow) begin
                state_nxt = S_PRD;
              end else if (can_grow) begin
                idx_nxt   = '0;
                state_nxt = S_GCLR;
              end else begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_DONE;
              end
            end
            OP_GET, OP_REMOVE: state_nxt = S_PRD;
            default: begin
              res_status_nxt = ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_GCLR: begin
        // empty the spare bank over the doubled size
        ram_we    = 1'b1;
        ram_wbank = !bank_r;
        ram_waddr = idx_r[AW-1:0];
        if (idx_r == nmask) begin
          idx_nxt   = '0;
          state_nxt = S_GRD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_GRD: begin
        ram_raddr = idx_r[AW-1:0];
        state_nxt = S_GCHK;
      end
      S_GCHK, S_GPCHK: begin
        logic advance;
        advance = 1'b0;
        if (state_r == S_GCHK) begin
          if (rd_act.tag > TAG_TOMB) begin
            gent_nxt  = rd_act;
            pidx_nxt  = rd_act.tag[AW-1:0] & nmask[AW-1:0];
            state_nxt = S_GPRD;
          end else begin
            advance = 1'b1;
          end
        end else if (rd_new.tag == TAG_EMPTY) begin
          ram_we    = 1'b1;
          ram_wbank = !bank_r;
          ram_waddr = pidx_r;
          ram_wdata = gent_r;
          advance   = 1'b1;
        end else begin
          pidx_nxt  = (pidx_r + 1'b1) & nmask[AW-1:0];
          state_nxt = S_GPRD;
        end
        // next old slot, or switch banks and probe for the pending set
        if (advance) begin
          if (last_i) begin
            bank_nxt   = !bank_r;
            size_nxt   = nsize;
            pidx_nxt   = hash_r[AW-1:0] & nmask[AW-1:0];
            nstep_nxt  = '0;
            tomb_v_nxt = 1'b0;
            state_nxt  = S_PRD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_GRD;
          end
        end
      end
      S_GPRD: begin
        state_nxt = S_GPCHK;
      end
      S_PRD: begin
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (resolve) begin
          state_nxt = S_DONE;
          case (op_r)
            OP_SET: begin
              if (found || free) begin
                ram_we         = 1'b1;
                ram_waddr      = found ? pidx_r : where;
                ram_wdata      = '{tag: hash_r, key: key_r, len: len_r, value: val_r};
                res_status_nxt = ST_OK;
                if (!found) count_nxt = count_r + 1'b1;
              end else begin
                res_status_nxt = ST_FULL;
              end
            end
            OP_GET: begin
              res_status_nxt = found ? ST_OK : ST_NOT_FOUND;
              res_value_nxt  = found ? rd_act.value : 64'd0;
            end
            default: begin
              if (found) begin
                ram_we         = 1'b1;
                ram_waddr      = pidx_r;
                ram_wdata      = '{tag: TAG_TOMB, key: 64'd0, len: 4'd0, value: 64'd0};
                count_nxt      = count_r - 1'b1;
                res_status_nxt = ST_OK;
              end else begin
                res_status_nxt = ST_NOT_FOUND;
              end
            end
          endcase
        end else begin
          if (rd_act.tag == TAG_TOMB && !tomb_v_r) begin
            tomb_v_nxt = 1'b1;
            tomb_nxt   = pidx_r;
          end
          pidx_nxt  = (pidx_r + 1'b1) & mask[AW-1:0];
          nstep_nxt = nstep_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_count_nxt  = 10'(count_r);
          out_size_nxt   = 11'(size_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // register write restarts the table
    if (cfg_wr_en) begin
      size_nxt  = round_size(cfg_wr_data);
      count_nxt = '0;
      idx_nxt   = '0;
      state_nxt = S_CLEAR;
    end
  end

  assign in_stall        = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value_out   = out_value_r;
  assign out_entry_count = out_count_r;
  assign out_table_size  = out_size_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      size_r      <= round_size(11'(MIN_SLOTS));
      count_r     <= '0;
      bank_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      count_r     <= count_nxt;
      bank_r      <= bank_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and probe registers
  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    nstep_r      <= nstep_nxt;
    tomb_v_r     <= tomb_v_nxt;
    tomb_r       <= tomb_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    val_r        <= val_nxt;
    hash_r       <= hash_nxt;
    hcnt_r       <= hcnt_nxt;
    gent_r       <= gent_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_size_r   <= out_size_nxt;
  end

  // load never passes half the table
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    {count_r, 1'b0} <= {1'b0, size_r})
    else $error("entry count above half the table size");

  // table size stays a power of two
  a_size_pow2: assert property (@(posedge clk) disable iff (!rst_n) $onehot(size_r))
    else $error("table size not a power of two");

  // a lookup never writes the table
  a_get_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_PCHK) |-> (op_r != OP_GET))
    else $error("table written during a get");

  // results appear only from the hand-over state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside hand-over");

endmodule

>>> verif/hash_table_linear_probe_core_test.sv
// testbench of the linear probing hash table core: scoreboard and stimulus
`timescale 1ns / 100ps

class htlp_scoreboard;
  // own copy of the table state
  logic [63:0] tag_mem [1024];
  logic [63:0] key_mem [1024];
  logic [3:0]  len_mem [1024];
  logic [63:0] val_mem [1024];
  int unsigned live_cnt;
  int unsigned size_now;

  logic [1:0]  exp_status [$];
  logic [63:0] exp_value [$];
  logic [9:0]  exp_count [$];
  logic [10:0] exp_size [$];
  int errors;

  function new();
    errors = 0;
    clear_all(8);
  endfunction

  function void clear_all(int unsigned sz);
    for (int i = 0; i < 1024; i++) begin
      tag_mem[i] = htlp_pkg::TAG_EMPTY;
      key_mem[i] = '0;
      len_mem[i] = '0;
      val_mem[i] = '0;
    end
    live_cnt = 0;
    size_now = sz;
  endfunction

  // start capacity rounded to power of two within 8..1024
  function void write_capacity(logic [10:0] cap);
    int unsigned p;
    p = 8;
    while (p < cap && p < 1024) p = p * 2;
    clear_all(p);
  endfunction

  function logic [63:0] fnv_hash(logic [63:0] key, int unsigned len);
    logic [63:0] h;
    h = htlp_pkg::FNV_BASIS;
    for (int i = 0; i < len; i++) begin
      h = h ^ ((key >> (8 * i)) & 64'hFF);
      h = h * 64'd1099511628211;
    end
    if (h < 2) h = 2;
    return h;
  endfunction

  // 1 found, 0 absent with insert slot, -1 absent and no room
  function int find_slot(logic [63:0] h, logic [63:0] key, logic [3:0] len,
                         output int unsigned where);
    int unsigned msk, idx, tomb;
    bit have_tomb;
    msk = size_now - 1;
    idx = 32'(h) & msk;
    have_tomb = 0;
    tomb = 0;
    where = 0;
    for (int n = 0; n < size_now; n++) begin
      if (tag_mem[idx] == htlp_pkg::TAG_EMPTY) begin
        where = have_tomb ? tomb : idx;
        return 0;
      end
      if (tag_mem[idx] == htlp_pkg::TAG_TOMB) begin
        if (!have_tomb) begin
          have_tomb = 1;
          tomb = idx;
        end
      end else if (tag_mem[idx] == h && len_mem[idx] == len && key_mem[idx] == key) begin
        where = idx;
        return 1;
      end
      idx = (idx + 1) & msk;
    end
    if (have_tomb) begin
      where = tomb;
      return 0;
    end
    return -1;
  endfunction

  function void grow_table();
    logic [63:0] ot [1024];
    logic [63:0] ok [1024];
    logic [3:0]  ol [1024];
    logic [63:0] ov [1024];
    int unsigned osz, w;
    osz = size_now;
    ot = tag_mem;
    ok = key_mem;
    ol = len_mem;
    ov = val_mem;
    clear_all(osz * 2);
    for (int i = 0; i < osz; i++) begin
      if (ot[i] > 1 && find_slot(ot[i], ok[i], ol[i], w) == 0) begin
        tag_mem[w] = ot[i];
        key_mem[w] = ok[i];
        len_mem[w] = ol[i];
        val_mem[w] = ov[i];
        live_cnt++;
      end
    end
  endfunction

  // note one accepted input transfer
  function void note_input(logic [1:0] op, logic [63:0] kb, logic [3:0] kl,
                           logic [63:0] vin);
    logic [3:0]  len;
    logic [63:0] key, h, res;
    logic [1:0]  st;
    int unsigned w;
    int r;
    bit ok;
    len = (kl > 8) ? 4'd8 : kl;
    key = (len >= 8) ? kb : (kb & ((64'd1 << (8 * len)) - 1));
    h = fnv_hash(key, len);
    st = htlp_pkg::ST_NOT_FOUND;
    res = '0;
    case (op)
      htlp_pkg::OP_SET: begin
        ok = 1;
        if (2 * (live_cnt + 1) > size_now) begin
          if (size_now * 2 <= 1024) grow_table();
          else ok = 0;
        end
        st = htlp_pkg::ST_FULL;
        if (ok) begin
          r = find_slot(h, key, len, w);
          if (r >= 0) begin
            tag_mem[w] = h;
            key_mem[w] = key;
            len_mem[w] = len;
            val_mem[w] = vin;
            if (r == 0) live_cnt++;
            st = htlp_pkg::ST_OK;
          end
        end
      end
      htlp_pkg::OP_GET: begin
        if (find_slot(h, key, len, w) == 1) begin
          st = htlp_pkg::ST_OK;
          res = val_mem[w];
        end
      end
      htlp_pkg::OP_REMOVE: begin
        if (find_slot(h, key, len, w) == 1) begin
          tag_mem[w] = htlp_pkg::TAG_TOMB;
          key_mem[w] = '0;
          len_mem[w] = '0;
          val_mem[w] = '0;
          live_cnt--;
          st = htlp_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    exp_status.push_back(st);
    exp_value.push_back(res);
    exp_count.push_back(live_cnt[9:0]);
    exp_size.push_back(size_now[10:0]);
  endfunction

  // compare one result transfer with the oldest expectation
  function void check_result(logic [1:0] st, logic [63:0] vo, logic [9:0] cnt,
                             logic [10:0] sz);
    logic [1:0]  es;
    logic [63:0] ev;
    logic [9:0]  ec;
    logic [10:0] ez;
    if (exp_status.size() == 0) begin
      $error("result with nothing expected");
      errors++;
      return;
    end
    es = exp_status.pop_front();
    ev = exp_value.pop_front();
    ec = exp_count.pop_front();
    ez = exp_size.pop_front();
    if (st !== es) begin
      $error("status expected %0d actual %0d", es, st);
      errors++;
    end
    if (vo !== ev) begin
      $error("value_out expected %h actual %h", ev, vo);
      errors++;
    end
    if (cnt !== ec) begin
      $error("entry_count expected %0d actual %0d", ec, cnt);
      errors++;
    end
    if (sz !== ez) begin
      $error("table_size expected %0d actual %0d", ez, sz);
      errors++;
    end
  endfunction

  function int pending();
    return exp_status.size();
  endfunction
endclass

module hash_table_linear_probe_core_test;
  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [63:0] in_key_bytes;
  logic [3:0]  in_key_length;
  logic [63:0] in_value_in;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [63:0] out_value_out;
  logic [9:0]  out_entry_count;
  logic [10:0] out_table_size;

  htlp_scoreboard board;
  int cycle_cnt;
  bit long_hold;
  bit stall_mode;
  logic [63:0] key_pool [16];
  logic [3:0]  len_pool [16];

  hash_table_linear_probe_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_key_bytes(in_key_bytes), .in_key_length(in_key_length),
    .in_value_in(in_value_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_value_out(out_value_out), .out_entry_count(out_entry_count),
    .out_table_size(out_table_size)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // generous cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: sample and check at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_status, out_value_out, out_entry_count, out_table_size);
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver stall pattern, with a long hold-off when requested
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        long_hold = 0;
        out_stall = 1'b0;
      end else if (stall_mode) begin
        n = gap_len();
        if (n > 0) begin
          out_stall = 1'b1;
          repeat (n - 1) @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  // offer one item and wait for its transfer
  task automatic send_item(logic [1:0] op, logic [63:0] kb, logic [3:0] kl,
                           logic [63:0] vin);
    in_op = op;
    in_key_bytes = kb;
    in_key_length = kl;
    in_value_in = vin;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(op, kb, kl, vin);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_gapped(logic [1:0] op, logic [63:0] kb, logic [3:0] kl,
                             logic [63:0] vin);
    int n;
    n = stall_mode ? gap_len() : 0;
    repeat (n) @(negedge clk);
    send_item(op, kb, kl, vin);
  endtask

  // wait for all results and an idle spell, then write capacity
  task automatic write_capacity(logic [10:0] cap);
    while (board.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = cap;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    board.write_capacity(cap);
  endtask

  task automatic random_phase(int count, int pool_n);
    int k;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, pool_n - 1);
      op = $urandom_range(0, 9) < 5 ? htlp_pkg::OP_SET :
           ($urandom_range(0, 1) ? htlp_pkg::OP_GET : htlp_pkg::OP_REMOVE);
      if ($urandom_range(0, 19) == 0) begin
        // noise: any opcode, any length, random key
        send_gapped(2'($urandom_range(0, 3)), {$urandom, $urandom},
                    4'($urandom_range(0, 15)), {$urandom, $urandom});
      end else begin
        // upper key bytes beyond the length are random junk
        send_gapped(op, key_pool[k] | ({$urandom, $urandom} << (8 * len_pool[k])) ,
                    len_pool[k], {$urandom, $urandom});
      end
    end
  endtask

  task automatic fill_pool(int maxlen);
    for (int i = 0; i < 16; i++) begin
      len_pool[i] = 4'($urandom_range(0, maxlen));
      key_pool[i] = {$urandom, $urandom};
      if (len_pool[i] < 8) key_pool[i] = key_pool[i] & ((64'd1 << (8 * len_pool[i])) - 1);
    end
  endtask

  initial begin
    board = new();
    cycle_cnt = 0;
    long_hold = 0;
    stall_mode = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_op = htlp_pkg::OP_SET;
    in_key_bytes = '0;
    in_key_length = '0;
    in_value_in = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: all ops, extreme fields, long key, unused opcode
    send_item(htlp_pkg::OP_GET, 64'h0, 4'd0, 64'h0);
    send_item(htlp_pkg::OP_SET, 64'h0, 4'd0, '1);
    send_item(htlp_pkg::OP_GET, 64'hFFFF, 4'd0, 64'h0);
    send_item(htlp_pkg::OP_SET, '1, 4'd15, 64'h1234);
    send_item(htlp_pkg::OP_GET, '1, 4'd8, 64'h0);
    send_item(htlp_pkg::OP_SET, 64'hAB, 4'd1, 64'h5);
    send_item(htlp_pkg::OP_SET, 64'hAB, 4'd1, 64'h6);
    send_item(htlp_pkg::OP_REMOVE, 64'hFF00AB, 4'd1, 64'h0);
    send_item(htlp_pkg::OP_REMOVE, 64'hAB, 4'd1, 64'h0);
    send_item(htlp_pkg::OP_GET, 64'hAB, 4'd1, 64'h0);
    send_item(2'd3, '1, 4'd8, '1);
    for (int i = 0; i < 8; i++)
      send_item(htlp_pkg::OP_SET, 64'h100 + i, 4'd2, i);
    send_item(htlp_pkg::OP_GET, 64'h103, 4'd2, 64'h0);

    // table full at the largest size is hard to reach; start at capacity 0, which rounds to eight slots
    stall_mode = 1;
    write_capacity(11'd0);
    fill_pool(8);
    random_phase(120, 16);

    // long receiver hold while sender keeps offering
    write_capacity(11'd20);
    fork
      random_phase(60, 16);
      begin
        @(negedge clk);
        long_hold = 1;
      end
    join

    write_capacity(11'd1024);
    fill_pool(3);
    random_phase(100, 16);

    write_capacity(11'd2047);
    random_phase(60, 16);

    // growth to the limit on a small capacity, then refused sets
    write_capacity(11'd8);
    stall_mode = 0;
    for (int i = 0; i < 520; i++)
      send_gapped(htlp_pkg::OP_SET, {$urandom, $urandom}, 4'd8, {$urandom, $urandom});
    stall_mode = 1;
    fill_pool(8);
    random_phase(50, 16);

    write_capacity(11'd9);
    random_phase(80, 16);

    // drain
    while (board.pending() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> hash_table_linear_probe_core.f
hw/rtl/htlp_pkg.sv
hw/rtl/htlp_ram.sv
hw/rtl/hash_table_linear_probe_core.sv
verif/hash_table_linear_probe_core_test.sv
